### hdl/life_pkg.sv
// Shared types and constants for the toroidal life automaton.
package life_pkg;

  localparam int GRID_COLS_DEF = 64;
  localparam int GRID_ROWS_DEF = 64;
  localparam int COORD_W       = 6;
  localparam int GEN_W         = 32;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_CLEAR,
    ST_CELL_RD,
    ST_CELL_UPD,
    ST_STEP_RD,
    ST_STEP_SH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic cnt_clr;
    logic cnt_inc;
    logic sweep_wr;
    logic cell_upd;
    logic step_rd;
    logic step_sh;
    logic step_end;
    logic gen_clr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic cnt_last;
    logic step_last;
    logic out_free;
  } sts_t;

endpackage

### hdl/life_ram.sv
// Generic single-port-write, registered-read RAM.
module life_ram #(
  parameter int WIDTH = life_pkg::GRID_COLS_DEF,
  parameter int DEPTH = life_pkg::GRID_ROWS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/life_ctrl.sv
// Controller state machine that sequences cell access, clear sweeps and generation steps.
module life_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  life_pkg::sts_t   sts,
  output life_pkg::cmd_t   cmd
);

  life_pkg::state_t state;
  life_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= life_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      life_pkg::ST_INIT: begin
        cmd.sweep_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = life_pkg::ST_IDLE;
        end
      end
      life_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept  = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_next  = life_pkg::ST_DISPATCH;
        end
      end
      life_pkg::ST_DISPATCH: begin
        case (sts.op)
          life_pkg::OP_WRITE, life_pkg::OP_READ: state_next = life_pkg::ST_CELL_RD;
          life_pkg::OP_STEP:                     state_next = life_pkg::ST_STEP_RD;
          default:                               state_next = life_pkg::ST_CLEAR;
        endcase
      end
      life_pkg::ST_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (sts.cnt_last) begin
          cmd.gen_clr = 1'b1;
          state_next  = life_pkg::ST_FINISH;
        end
      end
      // The row RAM reads the addressed row unconditionally in this cycle.
      life_pkg::ST_CELL_RD: begin
        state_next = life_pkg::ST_CELL_UPD;
      end
      life_pkg::ST_CELL_UPD: begin
        cmd.cell_upd = 1'b1;
        state_next   = life_pkg::ST_FINISH;
      end
      life_pkg::ST_STEP_RD: begin
        cmd.step_rd = 1'b1;
        state_next  = life_pkg::ST_STEP_SH;
      end
      life_pkg::ST_STEP_SH: begin
        cmd.step_sh = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.step_last) begin
          cmd.step_end = 1'b1;
          state_next   = life_pkg::ST_FINISH;
        end else begin
          state_next = life_pkg::ST_STEP_RD;
        end
      end
      life_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = life_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = life_pkg::ST_INIT;
      end
    endcase
  end

endmodule

### hdl/life_dp.sv
// Datapath: two row-wide grid banks, row window, life rule lanes, counters and result register.
module life_dp #(
  parameter int GRID_COLS = life_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = life_pkg::GRID_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  life_pkg::cmd_t                cmd,
  output life_pkg::sts_t                sts,
  input  logic [1:0]                    op,
  input  logic [life_pkg::COORD_W-1:0]  cell_x,
  input  logic [life_pkg::COORD_W-1:0]  cell_y,
  input  logic                          cell_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          read_value,
  output logic [life_pkg::GEN_W-1:0]    generation
);

  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int COL_W = $clog2(GRID_COLS);
  localparam int CNT_W = $clog2(GRID_ROWS + 2);

  function automatic logic life_rule(input logic alive, input logic [7:0] nbr);
    logic [3:0] sum;
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + 4'(nbr[i]);
    end
    return (sum == 4'd3) || (alive && (sum == 4'd2));
  endfunction

  life_pkg::op_t                 item_op;
  logic [life_pkg::COORD_W-1:0]  item_x;
  logic [life_pkg::COORD_W-1:0]  item_y;
  logic                          item_val;
  logic                          rd_bit;
  logic [CNT_W-1:0]              cnt;
  logic                          cur_bank;
  logic [life_pkg::GEN_W-1:0]    gen;
  logic [GRID_COLS-1:0]          row_up;
  logic [GRID_COLS-1:0]          row_ctr;

  logic                          in_grid;
  logic [ROW_W-1:0]              cell_row;
  logic [GRID_COLS-1:0]          col_mask;
  logic [ROW_W-1:0]              step_raddr;
  logic [ROW_W-1:0]              step_waddr;
  logic [ROW_W-1:0]              rd_addr;
  logic [GRID_COLS-1:0]          rdata;
  logic [GRID_COLS-1:0]          rdata0;
  logic [GRID_COLS-1:0]          rdata1;
  logic [GRID_COLS-1:0]          new_row;
  logic                          wr_en;
  logic                          wr_bank;
  logic [ROW_W-1:0]              wr_addr;
  logic [GRID_COLS-1:0]          wr_data;

  assign in_grid  = (int'(item_x) < GRID_COLS) && (int'(item_y) < GRID_ROWS);
  assign cell_row = ROW_W'(item_y);
  assign col_mask = {{(GRID_COLS - 1){1'b0}}, 1'b1} << COL_W'(item_x);

  // A step loads rows R-1, 0, 1, ..., R-1, 0 so the window always has the row above.
  always_comb begin
    if (cnt == '0) begin
      step_raddr = ROW_W'(GRID_ROWS - 1);
    end else if (cnt == CNT_W'(GRID_ROWS + 1)) begin
      step_raddr = '0;
    end else begin
      step_raddr = ROW_W'(cnt - CNT_W'(1));
    end
  end

  assign step_waddr = ROW_W'(cnt - CNT_W'(2));
  assign rd_addr    = cmd.step_rd ? step_raddr : cell_row;
  assign rdata      = cur_bank ? rdata1 : rdata0;

  // One lane per column: row_up is above, row_ctr is the row being updated, rdata is below.
  for (genvar c = 0; c < GRID_COLS; c++) begin : g_lane
    localparam int CL = (c == 0) ? GRID_COLS - 1 : c - 1;
    localparam int CR = (c == GRID_COLS - 1) ? 0 : c + 1;
    assign new_row[c] = life_rule(row_ctr[c], {row_up[CL], row_up[c], row_up[CR],
                                               row_ctr[CL], row_ctr[CR],
                                               rdata[CL], rdata[c], rdata[CR]});
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_bank = cur_bank;
    wr_addr = cell_row;
    wr_data = '0;
    if (cmd.sweep_wr) begin
      wr_en   = 1'b1;
      wr_addr = cnt[ROW_W-1:0];
    end else if (cmd.cell_upd) begin
      wr_en   = (item_op == life_pkg::OP_WRITE) && in_grid;
      wr_data = item_val ? (rdata | col_mask) : (rdata & ~col_mask);
    end else if (cmd.step_sh) begin
      // The first two loads only fill the window.
      wr_en   = cnt > CNT_W'(1);
      wr_bank = ~cur_bank;
      wr_addr = step_waddr;
      wr_data = new_row;
    end
  end

  life_ram #(.WIDTH(GRID_COLS), .DEPTH(GRID_ROWS)) u_bank0 (
    .clk     (clk),
    .wr_en   (wr_en && !wr_bank),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rdata0)
  );

  life_ram #(.WIDTH(GRID_COLS), .DEPTH(GRID_ROWS)) u_bank1 (
    .clk     (clk),
    .wr_en   (wr_en && wr_bank),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rdata1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      cur_bank  <= 1'b0;
      gen       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.step_end) begin
        cur_bank <= ~cur_bank;
      end
      if (cmd.gen_clr) begin
        gen <= '0;
      end else if (cmd.step_end) begin
        gen <= gen + life_pkg::GEN_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_op  <= life_pkg::op_t'(op);
      item_x   <= cell_x;
      item_y   <= cell_y;
      item_val <= cell_value;
      rd_bit   <= 1'b0;
    end else if (cmd.cell_upd) begin
      rd_bit <= (item_op == life_pkg::OP_READ) && in_grid && (|(rdata & col_mask));
    end
    if (cmd.step_sh) begin
      row_up  <= row_ctr;
      row_ctr <= rdata;
    end
    if (cmd.out_load) begin
      read_value <= rd_bit;
      generation <= gen;
    end
  end

  assign sts.op        = item_op;
  assign sts.cnt_last  = cnt == CNT_W'(GRID_ROWS - 1);
  assign sts.step_last = cnt == CNT_W'(GRID_ROWS + 1);
  assign sts.out_free  = !out_valid || out_ready;

`ifndef NO_ASSERTIONS
  a_gen_hold: assert property (@(posedge clk) disable iff (rst)
    (!cmd.step_end && !cmd.gen_clr) |=> $stable(gen))
    else $error("generation count changed outside a step or clear");

  a_gen_inc: assert property (@(posedge clk) disable iff (rst)
    (cmd.step_end && !cmd.gen_clr) |=> (gen == $past(gen) + life_pkg::GEN_W'(1)))
    else $error("generation count did not advance by one on a step");

  a_bank_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.step_end |=> $stable(cur_bank))
    else $error("grid bank swapped outside the end of a step");

  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result word loaded over one not yet taken");
`endif

endmodule

### hdl/life_automaton_torus.sv
// Top level of the toroidal life automaton: controller plus datapath.
// Conway's Game of Life on a GRID_COLS by GRID_ROWS torus, held as one row per RAM word
// in two banks that swap roles on each step. Every accepted word (write, read, step or
// clear) returns exactly one result word with the read bit and the generation count.
// After reset the block sweeps the current bank to all dead, one row per cycle, before
// in_ready first rises. A new word is accepted only after the previous one has loaded its
// result word. A step loads GRID_ROWS + 2 rows through the single RAM read port, reading
// and then shifting each row in turn, and the new row of all columns is formed at once
// from a three-row window and written to the other bank. A result that is not taken holds
// the next item in its final cycle until out_ready frees the output register.
module life_automaton_torus #(
  parameter int GRID_COLS = life_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = life_pkg::GRID_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    op,
  input  logic [life_pkg::COORD_W-1:0]  cell_x,
  input  logic [life_pkg::COORD_W-1:0]  cell_y,
  input  logic                          cell_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          read_value,
  output logic [life_pkg::GEN_W-1:0]    generation
);

  life_pkg::cmd_t cmd;
  life_pkg::sts_t sts;

  life_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  life_dp #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .op         (op),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_value (cell_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_value (read_value),
    .generation (generation)
  );

endmodule
